// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GCSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define GCSL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GCSL_ASSERT(lbl, prop, msg)
`define GCSL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/gcsl_pkg.sv =====
// Types, constants and functions of the Gray code structured-light decoder.
package gcsl_pkg;

    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;
    localparam int CODE_BITS  = 10;
    localparam int PIXELS     = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W     = $clog2(PIXELS);

    localparam int MODE_W   = 2;
    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int SAMPLE_W = 8;
    localparam int STAGE_W  = 4;
    localparam int PROJ_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_REF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MARGIN = 1'b1;

    localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 8'd50;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  black;
        logic [SAMPLE_W-1:0]  white;
        logic [CODE_BITS-1:0] code_col;
        logic [CODE_BITS-1:0] code_row;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ADDR_W-1:0]   addr;
        logic [X_W-1:0]      px;
        logic [Y_W-1:0]      py;
        logic [SAMPLE_W-1:0] sa;
        logic [SAMPLE_W-1:0] sb;
        logic                axis;
        logic [STAGE_W-1:0]  stage;
    } t_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr;

    typedef struct packed {
        logic              valid;
        logic [X_W-1:0]    cam_x;
        logic [Y_W-1:0]    cam_y;
        logic [PROJ_W-1:0] proj_row;
        logic [PROJ_W-1:0] proj_col;
        logic              ok;
    } t_res;

    function automatic logic [CODE_BITS-1:0] gray_to_bin(input logic [CODE_BITS-1:0] g);
        logic [CODE_BITS-1:0] b;
        for (int i = 0; i < CODE_BITS; i++) begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/gray_code_structured_light_decoder.sv =====
// Top level of the Gray code structured-light decoder: request pipeline around the pixel RAM.
// One request per cycle is sustained while o_in_stall is low. A request reads its pixel's word
// from a single 307200 x 36 RAM (one write and one read port, registered read data) at acceptance,
// updates it and writes it back in the next cycle; a write that collides with the read of
// the following request is forwarded. A readout result passes through the stage-1 register into
// the output register and waits there; input stall rises only
// while a readout request is held behind an occupied, stalled output. Requests with a pixel
// outside the image, mode 3, or a pattern stage beyond the code width are dropped. The RAM is
// not cleared after reset: reading a pixel before its reference request is unspecified.
module gray_code_structured_light_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gcsl_pkg::MODE_W-1:0]       i_mode,
    input  logic [gcsl_pkg::X_W-1:0]          i_pixel_x,
    input  logic [gcsl_pkg::Y_W-1:0]          i_pixel_y,
    input  logic [gcsl_pkg::SAMPLE_W-1:0]     i_sample_a,
    input  logic [gcsl_pkg::SAMPLE_W-1:0]     i_sample_b,
    input  logic                              i_axis,
    input  logic [gcsl_pkg::STAGE_W-1:0]      i_stage,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gcsl_pkg::X_W-1:0]          o_cam_x,
    output logic [gcsl_pkg::Y_W-1:0]          o_cam_y,
    output logic [gcsl_pkg::PROJ_W-1:0]       o_proj_row,
    output logic [gcsl_pkg::PROJ_W-1:0]       o_proj_col,
    output logic                              o_decoded_ok,
    input  logic                              i_cfg_we,
    input  logic [gcsl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcsl_pkg::SAMPLE_W-1:0]     i_cfg_data
);
    import gcsl_pkg::*;

    `include "assert_macros.svh"

    logic                r_s1_v;
    t_item               r_s1;
    logic                r_fwd_hit;
    t_entry              r_fwd_data;
    logic                r_out_v;
    t_res                r_out;
    logic [SAMPLE_W-1:0] r_black_margin;
    logic [SAMPLE_W-1:0] r_white_margin;

    logic                in_acc;
    logic                in_ok;
    logic                s1_adv;
    logic                out_free;
    logic                wr_fire;
    logic [ADDR_W-1:0]   new_addr;
    t_item               n_s1;
    logic [ENTRY_W-1:0]  rd_data;
    t_entry              s1_entry;
    t_wr                 wr;
    t_res                res;

    assign new_addr = ADDR_W'(i_pixel_y) * ADDR_W'(IMG_WIDTH) + ADDR_W'(i_pixel_x);

    assign in_ok = (32'(i_pixel_x) < 32'(IMG_WIDTH)) && (32'(i_pixel_y) < 32'(IMG_HEIGHT))
                && (i_mode == MODE_REF || i_mode == MODE_READ
                    || (i_mode == MODE_PAT && 32'(i_stage) < 32'(CODE_BITS)));

    assign out_free   = !r_out_v || !i_out_stall;
    assign s1_adv     = !r_s1_v || r_s1.mode != MODE_READ || out_free;
    assign o_in_stall = r_s1_v && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_fire    = r_s1_v && wr.we && s1_adv;

    assign n_s1 = '{mode: i_mode, addr: new_addr, px: i_pixel_x, py: i_pixel_y,
                    sa: i_sample_a, sb: i_sample_b, axis: i_axis, stage: i_stage};

    gcsl_ram #(
        .DEPTH (PIXELS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_fire),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (in_acc),
        .i_raddr (new_addr),
        .o_rdata (rd_data)
    );

    assign s1_entry = r_fwd_hit ? r_fwd_data : t_entry'(rd_data);

    gcsl_update u_update (
        .i_item         (r_s1),
        .i_entry        (s1_entry),
        .i_black_margin (r_black_margin),
        .i_white_margin (r_white_margin),
        .o_wr           (wr),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v         <= 1'b0;
            r_out_v        <= 1'b0;
            r_black_margin <= MARGIN_RESET;
            r_white_margin <= MARGIN_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLACK_MARGIN: r_black_margin <= i_cfg_data;
                    CFG_WHITE_MARGIN: r_white_margin <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s1_adv) begin
                r_s1_v <= in_acc && in_ok;
            end
            if (out_free) begin
                r_out_v <= r_s1_v && res.valid;
            end
        end
        if (in_acc) begin
            r_s1       <= n_s1;
            r_fwd_hit  <= wr_fire && (wr.addr == new_addr);
            r_fwd_data <= wr.data;
        end
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_cam_x      = r_out.cam_x;
    assign o_cam_y      = r_out.cam_y;
    assign o_proj_row   = r_out.proj_row;
    assign o_proj_col   = r_out.proj_col;
    assign o_decoded_ok = r_out.ok;

    `GCSL_ASSERT(a_read_no_write, (r_s1_v && r_s1.mode == MODE_READ) |-> !wr_fire, "readout request wrote the pixel RAM")
    `GCSL_ASSERT(a_fwd_data, (wr_fire && in_acc && in_ok && wr.addr == new_addr) |=> (s1_entry == $past(wr.data)), "colliding write not forwarded")
    `GCSL_ASSERT(a_stall_cause, o_in_stall |-> (r_out_v && i_out_stall), "input stalled with output free")
    `GCSL_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
endmodule

// ===== hw/rtl/gcsl_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gcsl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/gcsl_update.sv =====
// Per-pixel update: threshold a pattern pair, build the write-back word and the readout.
module gcsl_update (
    input  gcsl_pkg::t_item                   i_item,
    input  gcsl_pkg::t_entry                  i_entry,
    input  logic [gcsl_pkg::SAMPLE_W-1:0]     i_black_margin,
    input  logic [gcsl_pkg::SAMPLE_W-1:0]     i_white_margin,
    output gcsl_pkg::t_wr                     o_wr,
    output gcsl_pkg::t_res                    o_res
);
    import gcsl_pkg::*;

    logic [SAMPLE_W:0]      lo;
    logic signed [SAMPLE_W+1:0] hi;
    logic signed [SAMPLE_W+2:0] lo_x;
    logic signed [SAMPLE_W+2:0] hi_x;
    logic signed [SAMPLE_W+2:0] a_x;
    logic signed [SAMPLE_W+2:0] b_x;
    logic                   a_above;
    logic                   b_above;
    logic                   bit_set;
    logic [CODE_BITS-1:0]   add;
    logic [CODE_BITS-1:0]   bin_row;
    logic [CODE_BITS-1:0]   bin_col;
    t_entry                 upd;

    assign lo   = {1'b0, i_entry.black} + {1'b0, i_black_margin};
    assign hi   = $signed({2'b00, i_entry.white}) - $signed({2'b00, i_white_margin});
    assign lo_x = $signed({2'b00, lo});
    assign hi_x = {hi[SAMPLE_W+1], hi};
    assign a_x  = $signed({3'b000, i_item.sa});
    assign b_x  = $signed({3'b000, i_item.sb});

    assign a_above = (a_x > lo_x) && (a_x > hi_x);
    assign b_above = (b_x > lo_x) && (b_x > hi_x);
    assign bit_set = a_above && !b_above;
    assign add     = CODE_BITS'(1) << i_item.stage;

    assign bin_row = gray_to_bin(i_entry.code_row);
    assign bin_col = gray_to_bin(i_entry.code_col);

    always_comb begin
        upd = i_entry;
        if (i_item.axis) begin
            upd.code_row = i_entry.code_row | add;
        end else begin
            upd.code_col = i_entry.code_col | add;
        end
    end

    always_comb begin
        o_wr.addr = i_item.addr;
        o_wr.data = upd;
        o_wr.we   = 1'b0;
        case (i_item.mode)
            MODE_REF: begin
                o_wr.we   = 1'b1;
                o_wr.data = '{black: i_item.sa, white: i_item.sb, code_col: '0, code_row: '0};
            end
            MODE_PAT: begin
                o_wr.we = bit_set;
            end
            default: begin
                o_wr.we = 1'b0;
            end
        endcase
    end

    assign o_res.valid    = (i_item.mode == MODE_READ);
    assign o_res.cam_x    = i_item.px;
    assign o_res.cam_y    = i_item.py;
    assign o_res.proj_row = PROJ_W'(bin_row);
    assign o_res.proj_col = PROJ_W'(bin_col);
    assign o_res.ok       = (|bin_row) && (|bin_col);
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the Gray code structured-light decoder, with a per-pixel predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcsl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int HOLD_AFTER    = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [X_W-1:0]      px;
        logic [Y_W-1:0]      py;
        logic [SAMPLE_W-1:0] sa;
        logic [SAMPLE_W-1:0] sb;
        logic                axis;
        logic [STAGE_W-1:0]  stage;
    } t_request;

    typedef struct packed {
        logic [X_W-1:0]    cam_x;
        logic [Y_W-1:0]    cam_y;
        logic [PROJ_W-1:0] proj_row;
        logic [PROJ_W-1:0] proj_col;
        logic              ok;
    } t_readout;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  black;
        logic [SAMPLE_W-1:0]  white;
        logic [CODE_BITS-1:0] col_code;
        logic [CODE_BITS-1:0] row_code;
    } t_pixel;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    t_request              req_cur = '0;
    logic                  res_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [SAMPLE_W-1:0]   cfg_data = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [X_W-1:0]        o_cam_x;
    logic [Y_W-1:0]        o_cam_y;
    logic [PROJ_W-1:0]     o_proj_row;
    logic [PROJ_W-1:0]     o_proj_col;
    logic                  o_decoded_ok;

    t_request  requests_pending[$];
    t_readout  readouts_due[$];
    t_pixel    pixel_mem[int];
    bit        referenced[int];
    int        referenced_list[$];

    int black_margin = MARGIN_RESET;
    int white_margin = MARGIN_RESET;
    int send_gap_max = 15;
    int recv_gap_max = 15;
    int send_wait = 0;
    int recv_wait = 0;
    int req_taken = 0;
    int hold_left = 0;
    bit hold_armed = 1'b1;
    int quiet_cycles = 0;
    int errors = 0;

    wire req_fire = req_valid && !o_in_stall;
    wire res_fire = o_out_valid && !res_stall;

    gray_code_structured_light_decoder DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (req_cur.mode),
        .i_pixel_x    (req_cur.px),
        .i_pixel_y    (req_cur.py),
        .i_sample_a   (req_cur.sa),
        .i_sample_b   (req_cur.sb),
        .i_axis       (req_cur.axis),
        .i_stage      (req_cur.stage),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (res_stall),
        .o_cam_x      (o_cam_x),
        .o_cam_y      (o_cam_y),
        .o_proj_row   (o_proj_row),
        .o_proj_col   (o_proj_col),
        .o_decoded_ok (o_decoded_ok),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CODE_BITS-1:0] gray_decode(input logic [CODE_BITS-1:0] g);
        logic [CODE_BITS-1:0] b;
        b[CODE_BITS-1] = g[CODE_BITS-1];
        for (int i = CODE_BITS - 2; i >= 0; i--) begin
            b[i] = b[i+1] ^ g[i];
        end
        return b;
    endfunction

    function automatic bit decode_request(input t_request r, output t_readout res);
        int key, lo, hi;
        bit a_high, b_high;
        t_pixel p;
        logic [CODE_BITS-1:0] row_bin, col_bin;
        res = '0;
        if (r.px >= IMG_WIDTH || r.py >= IMG_HEIGHT) return 1'b0;
        key = int'(r.py) * IMG_WIDTH + int'(r.px);
        case (r.mode)
            MODE_REF: begin
                p.black = r.sa;
                p.white = r.sb;
                p.col_code = '0;
                p.row_code = '0;
                pixel_mem[key] = p;
            end
            MODE_PAT: begin
                if (r.stage < CODE_BITS) begin
                    p = pixel_mem[key];
                    lo = int'(p.black) + black_margin;
                    hi = int'(p.white) - white_margin;
                    a_high = int'(r.sa) > lo && int'(r.sa) > hi;
                    b_high = int'(r.sb) > lo && int'(r.sb) > hi;
                    if (a_high && !b_high) begin
                        if (r.axis) p.row_code[r.stage] = 1'b1;
                        else p.col_code[r.stage] = 1'b1;
                        pixel_mem[key] = p;
                    end
                end
            end
            MODE_READ: begin
                p = pixel_mem[key];
                row_bin = gray_decode(p.row_code);
                col_bin = gray_decode(p.col_code);
                res.cam_x = r.px;
                res.cam_y = r.py;
                res.proj_row = row_bin;
                res.proj_col = col_bin;
                res.ok = (row_bin != 0) && (col_bin != 0);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void push_req(input logic [MODE_W-1:0] mode, input int x, input int y,
                                     input int a, input int b, input int ax, input int st);
        t_request r;
        int key;
        r.mode = mode;
        r.px = X_W'(x);
        r.py = Y_W'(y);
        r.sa = SAMPLE_W'(a);
        r.sb = SAMPLE_W'(b);
        r.axis = ax[0];
        r.stage = STAGE_W'(st);
        requests_pending = {requests_pending, r};
        key = y * IMG_WIDTH + x;
        if (mode == MODE_REF && x < IMG_WIDTH && y < IMG_HEIGHT && !referenced.exists(key)) begin
            referenced[key] = 1'b1;
            referenced_list = {referenced_list, key};
        end
    endfunction

    function automatic void add_noise(input int count);
        int x, y, md, key;
        repeat (count) begin
            md = $urandom_range(MODE_REF, MODE_NONE);
            x = $urandom_range(0, 2**X_W - 1);
            y = $urandom_range(0, 2**Y_W - 1);
            key = y * IMG_WIDTH + x;
            // keep non-reference requests away from in-image pixels that never got references
            if (md != MODE_REF && x < IMG_WIDTH && y < IMG_HEIGHT && !referenced.exists(key)) begin
                if (referenced_list.size() == 0) begin
                    md = MODE_REF;
                end else begin
                    key = referenced_list[$urandom_range(0, referenced_list.size() - 1)];
                    x = key % IMG_WIDTH;
                    y = key / IMG_WIDTH;
                end
            end
            push_req(MODE_W'(md), x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 2**STAGE_W - 1));
        end
    endfunction

    function automatic void add_pixel_sequence(input int x, input int y);
        logic [CODE_BITS-1:0] target, gray_c, gray_r;
        logic bit_on;
        int a, b;
        target = CODE_BITS'($urandom);
        gray_c = target ^ (target >> 1);
        target = CODE_BITS'($urandom);
        gray_r = target ^ (target >> 1);
        if ($urandom_range(0, 3) == 0)
            push_req(MODE_REF, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15));
        else
            push_req(MODE_REF, x, y, $urandom_range(0, 80), $urandom_range(170, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15));
        for (int st = 0; st < CODE_BITS; st++) begin
            for (int ax = 0; ax < 2; ax++) begin
                bit_on = ax ? gray_r[st] : gray_c[st];
                if ($urandom_range(0, 3) == 0) begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end else if (bit_on) begin
                    a = $urandom_range(200, 255);
                    b = $urandom_range(0, 60);
                end else begin
                    a = $urandom_range(0, 60);
                    b = $urandom_range(200, 255);
                end
                push_req(MODE_PAT, x, y, a, b, ax, st);
                if ($urandom_range(0, 4) == 0)
                    push_req(MODE_READ, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 1), $urandom_range(0, 15));
            end
        end
        push_req(MODE_READ, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 15));
    endfunction

    task automatic settle_pipeline();
        while (requests_pending.size() > 0 || req_valid || readouts_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_margin(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= SAMPLE_W'(value);
        if (idx == CFG_BLACK_MARGIN) black_margin = value;
        else white_margin = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin
        t_readout predicted;
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_wait <= 0;
        end else if (!req_valid || req_fire) begin
            if (req_fire) begin
                req_taken <= req_taken + 1;
                if (decode_request(req_cur, predicted)) readouts_due = {readouts_due, predicted};
            end
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                req_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
                req_cur <= requests_pending.pop_front();
                req_valid <= 1'b1;
                send_wait <= $urandom_range(0, send_gap_max);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_readout want;
        int wait_next;
        if (!rst_n) begin
            res_stall <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (res_fire) begin
                if (readouts_due.size() == 0) begin
                    $error("readout with none pending: cam_x %0d cam_y %0d", o_cam_x, o_cam_y);
                    errors++;
                end else begin
                    want = readouts_due.pop_front();
                    if (o_cam_x !== want.cam_x) begin
                        $error("cam_x: expected %0d, got %0d", want.cam_x, o_cam_x);
                        errors++;
                    end
                    if (o_cam_y !== want.cam_y) begin
                        $error("cam_y: expected %0d, got %0d", want.cam_y, o_cam_y);
                        errors++;
                    end
                    if (o_proj_row !== want.proj_row) begin
                        $error("proj_row: expected %0d, got %0d", want.proj_row, o_proj_row);
                        errors++;
                    end
                    if (o_proj_col !== want.proj_col) begin
                        $error("proj_col: expected %0d, got %0d", want.proj_col, o_proj_col);
                        errors++;
                    end
                    if (o_decoded_ok !== want.ok) begin
                        $error("decoded_ok: expected %0d, got %0d", want.ok, o_decoded_ok);
                        errors++;
                    end
                end
                wait_next = $urandom_range(0, recv_gap_max);
            end else begin
                wait_next = (recv_wait > 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= wait_next;
            res_stall <= (wait_next > 0) || (hold_left > 1);
        end
    end

    // hold the output once for a long stretch so the input backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && req_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || req_fire || res_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int bm, wm, x, y;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        push_req(MODE_REF, 0, 0, 0, 255, 0, 0);
        push_req(MODE_REF, IMG_WIDTH - 1, IMG_HEIGHT - 1, 255, 0, 1, 2**STAGE_W - 1);
        push_req(MODE_PAT, 0, 0, 255, 0, 0, 0);
        push_req(MODE_PAT, 0, 0, 255, 0, 1, CODE_BITS - 1);
        push_req(MODE_PAT, 0, 0, 255, 255, 0, CODE_BITS - 1);
        push_req(MODE_PAT, 0, 0, 0, 0, 1, 0);
        push_req(MODE_PAT, 0, 0, 255, 0, 0, CODE_BITS);
        push_req(MODE_PAT, 0, 0, 255, 0, 1, 2**STAGE_W - 1);
        push_req(MODE_READ, 0, 0, 0, 0, 0, 0);
        push_req(MODE_NONE, 0, 0, 255, 255, 1, 3);
        push_req(MODE_REF, IMG_WIDTH, 0, 10, 20, 0, 0);
        push_req(MODE_READ, 0, IMG_HEIGHT, 0, 0, 0, 0);
        push_req(MODE_PAT, 2**X_W - 1, 2**Y_W - 1, 255, 0, 1, 5);
        push_req(MODE_PAT, IMG_WIDTH - 1, IMG_HEIGHT - 1, 255, 0, 0, 5);
        push_req(MODE_READ, IMG_WIDTH - 1, IMG_HEIGHT - 1, 255, 255, 1, 15);
        push_req(MODE_PAT, 0, 0, 206, 205, 0, 1);
        push_req(MODE_PAT, 0, 0, 205, 0, 1, 1);
        push_req(MODE_READ, 0, 0, 0, 0, 0, 0);
        push_req(MODE_REF, 1, 0, 0, 10, 0, 0);
        push_req(MODE_PAT, 1, 0, 60, 0, 0, 3);
        push_req(MODE_READ, 1, 0, 0, 0, 0, 0);
        push_req(MODE_REF, 0, 0, 0, 255, 0, 0);
        push_req(MODE_READ, 0, 0, 0, 0, 0, 0);
        settle_pipeline();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin bm = 0; wm = 0; end
                1: begin bm = 255; wm = 255; end
                2: begin bm = 0; wm = 255; end
                3: begin bm = 255; wm = 0; end
                default: begin bm = $urandom_range(0, 255); wm = $urandom_range(0, 255); end
            endcase
            write_margin(CFG_BLACK_MARGIN, bm);
            write_margin(CFG_WHITE_MARGIN, wm);
            send_gap_max = (ph % 3 == 1) ? 0 : 15;
            recv_gap_max = (ph % 3 == 2) ? 0 : 15;
            for (int s = 0; s < 2; s++) begin
                add_noise(4);
                x = ($urandom_range(0, 7) == 0) ? IMG_WIDTH - 1 : $urandom_range(0, IMG_WIDTH - 1);
                y = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, IMG_HEIGHT - 1);
                add_pixel_sequence(x, y);
            end
            add_noise(4);
            settle_pipeline();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && readouts_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== gray_code_structured_light_decoder.f =====
+incdir+hw/rtl
hw/rtl/gcsl_pkg.sv
hw/rtl/gcsl_ram.sv
hw/rtl/gcsl_update.sv
hw/rtl/gray_code_structured_light_decoder.sv
test/tb_top.sv
